@@ sv/jfop_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfop_pkg - shared types and constants for the job queue
// Request codes, port field widths, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package jfop_pkg;

  localparam int DEF_QUEUE_DEPTH = 256;
  localparam int DEF_OWNER_WIDTH = 16;
  localparam int DEF_ARG_WIDTH   = 32;

  // port field widths
  localparam int REQ_W        = 2;
  localparam int OWNER_PORT_W = 16;
  localparam int CODE_W       = 16;
  localparam int ARG_PORT_W   = 32;
  localparam int FILL_W       = 9;
  localparam int S_TDATA_W    = 64;
  localparam int S_TUSER_W    = 2;
  localparam int M_TDATA_W    = 80;
  localparam int M_TUSER_W    = 2;

  typedef logic [REQ_W-1:0] req_t;
  localparam req_t REQ_PUSH  = 2'd0;
  localparam req_t REQ_PRUNE = 2'd1;
  localparam req_t REQ_POP   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_POP_DATA,
    ST_SCAN,
    ST_PRUNE_DONE
  } state_t;

  typedef struct packed {
    logic latch_req;
    logic do_push;
    logic pop_issue;
    logic pop_commit;
    logic scan_init;
    logic scan_read;
    logic scan_check;
    logic prune_commit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    req_t req_type;
    logic empty;
    logic scan_more;
  } stat_t;

endpackage

@@ sv/jfop_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfop_ctrl - request sequencer for the job queue
// Walks each request through decode, any memory read it needs and result
// load; owns the output valid flag and the prune read pipeline flag.
// ----------------------------------------------------------------------------
module jfop_ctrl import jfop_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  output logic  m_tvalid,
  input  logic  m_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic   rd_pend, rd_pend_next;
  logic   m_tvalid_next;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_pend  <= rd_pend_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    s_tready     = 1'b0;
    rd_pend_next = 1'b0;
    out_free     = !m_tvalid || m_tready;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch_req = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.req_type)
          REQ_PUSH: begin
            if (out_free) begin
              cmd.do_push  = 1'b1;
              cmd.load_out = 1'b1;
              state_next   = ST_IDLE;
            end
          end
          REQ_PRUNE: begin
            cmd.scan_init = 1'b1;
            state_next    = ST_SCAN;
          end
          REQ_POP: begin
            if (!stat.empty) begin
              cmd.pop_issue = 1'b1;
              state_next    = ST_POP_DATA;
            end else if (out_free) begin
              cmd.load_out = 1'b1;
              state_next   = ST_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              cmd.load_out = 1'b1;
              state_next   = ST_IDLE;
            end
          end
        endcase
      end
      ST_POP_DATA: begin
        if (out_free) begin
          cmd.pop_commit = 1'b1;
          cmd.load_out   = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // read entry i while checking entry i-1
        cmd.scan_read  = stat.scan_more;
        cmd.scan_check = rd_pend;
        rd_pend_next   = stat.scan_more;
        if (!stat.scan_more && !rd_pend) begin
          state_next = ST_PRUNE_DONE;
        end
      end
      ST_PRUNE_DONE: begin
        if (out_free) begin
          cmd.prune_commit = 1'b1;
          cmd.load_out     = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    m_tvalid_next = cmd.load_out ? 1'b1 : (m_tready ? 1'b0 : m_tvalid);
  end

  a_check_follows_read: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_check |-> $past(cmd.scan_read))
    else $error("prune check without a read in the previous cycle");

  a_single_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.do_push, cmd.pop_issue, cmd.pop_commit, cmd.scan_init, cmd.prune_commit}))
    else $error("more than one queue operation in a cycle");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result loaded over an untaken result");

endmodule

@@ sv/jfop_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfop_dpath - job queue storage and result register
// Circular entry memory with head pointer and count, the prune
// compaction pointers, and the registered result fields.
// ----------------------------------------------------------------------------
module jfop_dpath import jfop_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int OWNER_WIDTH = DEF_OWNER_WIDTH,
  parameter int ARG_WIDTH   = DEF_ARG_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  req_t                    req_in,
  input  logic [OWNER_PORT_W-1:0] owner_in,
  input  logic [CODE_W-1:0]       code_in,
  input  logic [ARG_PORT_W-1:0]   arg_in,
  output logic                    out_job_valid,
  output logic                    out_overflowed,
  output logic [CODE_W-1:0]       out_code,
  output logic [ARG_PORT_W-1:0]   out_argument,
  output logic [OWNER_PORT_W-1:0] out_owner,
  output logic [FILL_W-1:0]       out_fill
);

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int ENTRY_W = OWNER_WIDTH + CODE_W + ARG_WIDTH;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  // entry layout: {owner, code, argument}
  logic [ENTRY_W-1:0]     mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0]     rd_data;

  req_t                   req_type;
  logic [OWNER_WIDTH-1:0] req_owner;
  logic [CODE_W-1:0]      req_code;
  logic [ARG_WIDTH-1:0]   req_arg;

  logic [PTR_W-1:0]       head, head_next;
  logic [CNT_W-1:0]       count, count_next;
  logic [CNT_W-1:0]       scan_idx;
  logic [CNT_W-1:0]       keep;

  logic                   wr_en, rd_en;
  logic [PTR_W-1:0]       wr_addr, rd_addr;
  logic [ENTRY_W-1:0]     wr_data;
  logic                   full, empty, match;
  logic [OWNER_WIDTH-1:0] rd_owner;
  logic [CODE_W-1:0]      rd_code;
  logic [ARG_WIDTH-1:0]   rd_arg;

  // head + offset modulo depth, offset never above depth
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return PTR_W'(s);
  endfunction

  assign full     = (count == DEPTH_C);
  assign empty    = (count == '0);
  assign rd_owner = rd_data[ENTRY_W-1 -: OWNER_WIDTH];
  assign rd_code  = rd_data[ARG_WIDTH +: CODE_W];
  assign rd_arg   = rd_data[ARG_WIDTH-1:0];
  assign match    = (rd_owner == req_owner);

  assign stat.req_type  = req_type;
  assign stat.empty     = empty;
  assign stat.scan_more = (scan_idx < count);

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = wrap_add(head, count);
    wr_data    = {req_owner, req_code, req_arg};
    rd_en      = 1'b0;
    rd_addr    = head;
    count_next = count;
    head_next  = head;
    if (cmd.do_push) begin
      if (full) begin
        count_next = '0;
      end else begin
        wr_en      = 1'b1;
        count_next = count + 1'b1;
      end
    end
    if (cmd.pop_issue) begin
      rd_en = 1'b1;
    end
    if (cmd.pop_commit) begin
      head_next  = wrap_add(head, CNT_W'(1));
      count_next = count - 1'b1;
    end
    if (cmd.scan_read) begin
      rd_en   = 1'b1;
      rd_addr = wrap_add(head, scan_idx);
    end
    if (cmd.scan_check && !match) begin
      // survivor slides down to the compacted position
      wr_en   = 1'b1;
      wr_addr = wrap_add(head, keep);
      wr_data = rd_data;
    end
    if (cmd.prune_commit) begin
      count_next = keep;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      scan_idx <= '0;
      keep     <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
      if (cmd.scan_init) begin
        scan_idx <= '0;
      end else if (cmd.scan_read) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (cmd.scan_init) begin
        keep <= '0;
      end else if (cmd.scan_check && !match) begin
        keep <= keep + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_type  <= req_in;
      req_owner <= OWNER_WIDTH'(owner_in);
      req_code  <= code_in;
      req_arg   <= ARG_WIDTH'(arg_in);
    end
    if (cmd.load_out) begin
      out_job_valid  <= cmd.pop_commit;
      out_overflowed <= cmd.do_push && full;
      out_code       <= cmd.pop_commit ? rd_code : '0;
      out_argument   <= cmd.pop_commit ? ARG_PORT_W'(rd_arg) : '0;
      out_owner      <= cmd.pop_commit ? OWNER_PORT_W'(rd_owner) : '0;
      out_fill       <= FILL_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count beyond queue depth");

  a_keep_behind: assert property (@(posedge clk) disable iff (rst)
    keep <= scan_idx)
    else $error("prune write pointer ahead of read pointer");

  a_overflow_result: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out && cmd.do_push && full |=> out_overflowed && out_fill == '0)
    else $error("overflow result does not report an empty queue");

endmodule

@@ sv/job_fifo_with_owner_purge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// job_fifo_with_owner_purge - bounded job queue with per-owner purge
// Top level: stream ports, field packing, controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel: s_tuser carries the request kind (push,
//   prune by owner, pop), s_tdata the owner tag, job code and argument. Every
//   request returns exactly one result on the m_ channel: m_tuser carries the
//   job-valid and overflow flags, m_tdata the popped entry and the fill level.
//   Timing: a push, an undefined kind or a pop of an empty queue passes
//   through the decode state, which loads the result and raises m_tvalid;
//   a pop needs one registered memory read of the head entry before its
//   result load. A prune walks the queue through the single read port,
//   one entry a cycle with compaction writes overlapped, then loads its
//   result once the walk is done. One request is worked on at a time.
//   The result sits in an output register, so a new request is accepted while
//   a result still waits on m_tready; the block only holds its final step if
//   that register is still occupied when the next result is ready.
//   Reset (rst, synchronous) empties the queue at once: head and count clear,
//   the memory itself is not swept, no request is blocked after reset.
//   A push into a full queue drops the new job and empties the queue.
// ----------------------------------------------------------------------------
module job_fifo_with_owner_purge import jfop_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int OWNER_WIDTH = DEF_OWNER_WIDTH,
  parameter int ARG_WIDTH   = DEF_ARG_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // owner_tag[15:0], job_code[31:16],
                                         // job_argument[63:32]
  input  logic [S_TUSER_W-1:0] s_tuser,  // req_type[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // out_code[15:0], out_argument[47:16],
                                         // out_owner[63:48], fill_level[72:64],
                                         // zero[79:73]
  output logic [M_TUSER_W-1:0] m_tuser   // job_valid[0], overflowed[1]
);

  cmd_t                    cmd;
  stat_t                   stat;
  logic                    out_job_valid;
  logic                    out_overflowed;
  logic [CODE_W-1:0]       out_code;
  logic [ARG_PORT_W-1:0]   out_argument;
  logic [OWNER_PORT_W-1:0] out_owner;
  logic [FILL_W-1:0]       out_fill;

  jfop_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  jfop_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .OWNER_WIDTH (OWNER_WIDTH),
    .ARG_WIDTH   (ARG_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_in         (s_tuser[REQ_W-1:0]),
    .owner_in       (s_tdata[OWNER_PORT_W-1:0]),
    .code_in        (s_tdata[OWNER_PORT_W +: CODE_W]),
    .arg_in         (s_tdata[OWNER_PORT_W+CODE_W +: ARG_PORT_W]),
    .out_job_valid  (out_job_valid),
    .out_overflowed (out_overflowed),
    .out_code       (out_code),
    .out_argument   (out_argument),
    .out_owner      (out_owner),
    .out_fill       (out_fill)
  );

  // pack result fields, lowest field first, zero fill to a byte boundary
  assign m_tdata = {{(M_TDATA_W-FILL_W-OWNER_PORT_W-ARG_PORT_W-CODE_W){1'b0}},
                    out_fill, out_owner, out_argument, out_code};
  assign m_tuser = {out_overflowed, out_job_valid};

endmodule

@@ tb/job_fifo_with_owner_purge_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// job_fifo_with_owner_purge_tb - self-checking bench for the job queue
// Sends push, prune, pop and undefined requests through the s_ stream and
// keeps a behavioral copy of the queue. Every m_ result is checked field
// by field against that copy, or against a hand-checked result for the
// typed rows of the short directed table run first. Random traffic follows
// with fill-to-full and overflow runs. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module job_fifo_with_owner_purge_tb;
  import jfop_pkg::*;

  localparam int   DEPTH       = DEF_QUEUE_DEPTH;
  localparam req_t REQ_UNDEF   = 2'd3;          // request code with no meaning
  localparam int   RAND_ITEMS  = 850;
  localparam int   TAIL_CYCLES = DEPTH + 40;    // longer than a full-queue prune
  localparam int   LONG_HOLD   = 120;           // sink hold-off, in cycles
  localparam int   MAX_PRINTS  = 60;

  typedef struct packed {
    logic [OWNER_PORT_W-1:0] owner;
    logic [CODE_W-1:0]       code;
    logic [ARG_PORT_W-1:0]   argument;
  } job_entry_t;

  typedef struct packed {
    logic                    job_valid;
    logic [CODE_W-1:0]       code;
    logic [ARG_PORT_W-1:0]   argument;
    logic [OWNER_PORT_W-1:0] owner;
    logic                    overflowed;
    logic [FILL_W-1:0]       fill;
  } job_result_t;

  typedef struct packed {
    req_t                    req;
    logic [OWNER_PORT_W-1:0] owner;
    logic [CODE_W-1:0]       code;
    logic [ARG_PORT_W-1:0]   argument;
    logic                    typed;     // res below was worked out by hand
    job_result_t             res;
  } dir_row_t;

  // Directed requests. Result fields: valid, code, argument, owner, overflow, fill.
  localparam dir_row_t DIR_TABLE [22] = '{
    // empty queue after reset: pop, prune and an undefined request
    '{REQ_POP,   16'h0000, 16'h0000, 32'h0000_0000, 1'b1,
      '{1'b0, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0, 9'd0}},
    '{REQ_PRUNE, 16'h1234, 16'h0000, 32'h0000_0000, 1'b1,
      '{1'b0, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0, 9'd0}},
    '{REQ_UNDEF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
      '{1'b0, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0, 9'd0}},
    // field extremes in and back out
    '{REQ_PUSH,  16'h0000, 16'h0000, 32'h0000_0000, 1'b1,
      '{1'b0, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0, 9'd1}},
    '{REQ_PUSH,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
      '{1'b0, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0, 9'd2}},
    '{REQ_POP,   16'h0000, 16'h0000, 32'h0000_0000, 1'b1,
      '{1'b1, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0, 9'd1}},
    '{REQ_POP,   16'h0000, 16'h0000, 32'h0000_0000, 1'b1,
      '{1'b1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 9'd0}},
    '{REQ_POP,   16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
      '{1'b0, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0, 9'd0}},
    // interleaved owners, then prunes that hit and miss
    '{REQ_PUSH,  16'h00A1, 16'h0001, 32'h0000_0011, 1'b0, '0},
    '{REQ_PUSH,  16'h00B2, 16'h0002, 32'h0000_0022, 1'b0, '0},
    '{REQ_PUSH,  16'h00A1, 16'h0003, 32'h0000_0033, 1'b0, '0},
    '{REQ_PUSH,  16'h00B2, 16'h0004, 32'h0000_0044, 1'b0, '0},
    '{REQ_PUSH,  16'h00A1, 16'h0005, 32'h0000_0055, 1'b0, '0},
    '{REQ_UNDEF, 16'h00A1, 16'h0000, 32'h0000_0000, 1'b1,
      '{1'b0, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0, 9'd5}},
    '{REQ_PRUNE, 16'h00C3, 16'h0000, 32'h0000_0000, 1'b0, '0},
    '{REQ_PRUNE, 16'h00A1, 16'h0000, 32'h0000_0000, 1'b0, '0},
    '{REQ_POP,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0, '0},
    '{REQ_PUSH,  16'h5A5A, 16'hA5A5, 32'h5A5A_5A5A, 1'b0, '0},
    '{REQ_PRUNE, 16'h00B2, 16'h0000, 32'h0000_0000, 1'b0, '0},
    '{REQ_POP,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0, '0},
    '{REQ_POP,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0, '0},
    '{REQ_PRUNE, 16'hFFFF, 16'h0000, 32'h0000_0000, 1'b0, '0}
  };

  // a few owners reused often, so prunes actually remove entries
  localparam logic [OWNER_PORT_W-1:0] OWNER_POOL [6] = '{
    16'h0000, 16'hFFFF, 16'h00A1, 16'h5A5A, 16'h8000, 16'h0001
  };

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [S_TUSER_W-1:0] s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  job_entry_t  queue_copy[$];        // queued jobs, oldest first
  job_result_t pending_results[$];   // results owed by the block, oldest first
  int          err_cnt           = 0;
  int          requests_accepted = 0;
  int          stim_count        = 0;
  int          burst_left        = 0;

  always #2 clk = ~clk;

  job_fifo_with_owner_purge dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  task automatic flag_error(input string msg);
    if (err_cnt < MAX_PRINTS) $display("ERROR at %0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Applies one request to the queue copy and returns the result it owes.
  function automatic job_result_t predict_queue_result(
    input req_t req, input logic [15:0] owner, input logic [15:0] code,
    input logic [31:0] argument);
    job_entry_t  kept[$];
    job_entry_t  head;
    job_result_t res;
    res = '0;
    case (req)
      REQ_PUSH: begin
        if (queue_copy.size() < DEPTH) begin
          queue_copy.push_back('{owner, code, argument});
        end else begin
          // full: new job dropped, whole queue flushed
          queue_copy.delete();
          res.overflowed = 1'b1;
        end
      end
      REQ_PRUNE: begin
        foreach (queue_copy[i])
          if (queue_copy[i].owner != owner) kept.push_back(queue_copy[i]);
        queue_copy = kept;
      end
      REQ_POP: begin
        if (queue_copy.size() > 0) begin
          head          = queue_copy.pop_front();
          res.job_valid = 1'b1;
          res.code      = head.code;
          res.argument  = head.argument;
          res.owner     = head.owner;
        end
      end
      default: ;
    endcase
    res.fill = FILL_W'(queue_copy.size());
    return res;
  endfunction

  function automatic logic [15:0] pick_owner();
    if ($urandom_range(0, 3) != 0) return OWNER_POOL[$urandom_range(0, 5)];
    return 16'($urandom);
  endfunction

  // Offers one request, in bursts with random gaps, and records the result
  // it owes once the block takes it.
  task automatic issue_request(input req_t req, input logic [15:0] owner,
                               input logic [15:0] code, input logic [31:0] argument,
                               input logic typed, input job_result_t typed_res);
    job_result_t res;
    int          gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk) s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      // now and then a long burst with no gaps at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {argument, code, owner};
    do @(posedge clk); while (!s_tready);
    res = predict_queue_result(req, owner, code, argument);
    pending_results.push_back(typed ? typed_res : res);
    requests_accepted++;
    if (req != REQ_UNDEF) stim_count++;
  endtask

  task automatic run_mixed(input int n);
    int   pick;
    int   stop_at;
    req_t req;
    stop_at = stim_count + n;
    while (stim_count < stop_at) begin
      pick = $urandom_range(0, 99);
      req  = (pick < 45) ? REQ_PUSH : (pick < 77) ? REQ_POP :
             (pick < 95) ? REQ_PRUNE : REQ_UNDEF;
      issue_request(req, pick_owner(), 16'($urandom), $urandom, 1'b0, '0);
    end
  endtask

  // Pushes random jobs until the queue is full, plus one more to overflow if asked.
  task automatic fill_to_full(input bit overflow);
    while (queue_copy.size() < DEPTH)
      issue_request(REQ_PUSH, pick_owner(), 16'($urandom), $urandom, 1'b0, '0);
    if (overflow)
      issue_request(REQ_PUSH, pick_owner(), 16'($urandom), $urandom, 1'b0, '0);
  endtask

  // Result sink: stall modes of its own, plus one long hold-off while the
  // source keeps pushing, so the output register fills and s_tready drops.
  initial begin : sink_drive
    int mode;
    int span;
    int tick;
    bit held;
    m_tready = 1'b0;
    held     = 1'b0;
    tick     = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && requests_accepted >= 200) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(8, 64);
      repeat (span) begin
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= ((tick % 5) >= 2);
        endcase
        tick++;
        @(negedge clk);
      end
    end
  end

  // Result checker, sampled at the rising edge.
  always @(posedge clk) begin
    job_result_t got;
    job_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser[0], m_tdata[15:0], m_tdata[47:16], m_tdata[63:48],
              m_tuser[1], m_tdata[72:64]};
      if (pending_results.size() == 0) begin
        flag_error("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("job_valid",    32'(got.job_valid),  32'(want.job_valid));
        check_field("out_code",     32'(got.code),       32'(want.code));
        check_field("out_argument", got.argument,        want.argument);
        check_field("out_owner",    32'(got.owner),      32'(want.owner));
        check_field("overflowed",   32'(got.overflowed), 32'(want.overflowed));
        check_field("fill_level",   32'(got.fill),       32'(want.fill));
      end
    end
  end

  initial begin : stimulus
    int drain;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = REQ_PUSH;
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (DIR_TABLE[i])
      issue_request(DIR_TABLE[i].req, DIR_TABLE[i].owner, DIR_TABLE[i].code,
                    DIR_TABLE[i].argument, DIR_TABLE[i].typed, DIR_TABLE[i].res);

    // random traffic, with full-queue episodes: pop and prune at full,
    // then overflow twice
    run_mixed(150);
    fill_to_full(1'b0);
    issue_request(REQ_POP, pick_owner(), 16'($urandom), $urandom, 1'b0, '0);
    issue_request(REQ_PUSH, pick_owner(), 16'($urandom), $urandom, 1'b0, '0);
    issue_request(REQ_PRUNE, OWNER_POOL[$urandom_range(0, 5)], 16'($urandom),
                  $urandom, 1'b0, '0);
    fill_to_full(1'b1);
    run_mixed(120);
    fill_to_full(1'b1);
    if (stim_count < RAND_ITEMS) run_mixed(RAND_ITEMS - stim_count);

    @(negedge clk) s_tvalid <= 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < 20 * DEPTH) begin
      @(posedge clk);
      drain++;
    end
    // catch stray extra results
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_results.size()));

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("TIMEOUT: run did not finish");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
